// File: hw/rtl/tte_pkg.sv
// tte_pkg: shared types, codes and defaults of the timeout table engine
// no dependencies; imported by tte_alu, tte_slot_mem and timeout_table_engine
package tte_pkg;

   // defaults for the top-level parameters
   localparam int SLOTS_DEF   = 16;
   localparam int ID_BITS_DEF = 16;

   // fixed field widths
   localparam int TIME_W  = 48;
   localparam int DELAY_W = 24;
   localparam int CID_W   = 16;
   localparam int OP_W    = 2;
   localparam int KIND_W  = 2;
   localparam int STAT_W  = 2;
   localparam int OCNT_W  = 5;
   localparam int TOT_W   = 32;
   localparam int INTV_W  = 16;

   localparam logic [INTV_W-1:0] TICK_INTV_RST = 16'd10;

   // request opcodes
   localparam logic [OP_W-1:0] OP_SCHED  = 2'd0;
   localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

   // response kinds
   localparam logic [KIND_W-1:0] KIND_SCHED   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CANCEL  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;
   localparam logic [KIND_W-1:0] KIND_IDLE    = 2'd3;

   // response status
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

   // sequencer states, one-hot
   typedef enum logic [5:0] {
      S_IDLE        = 6'b000001,
      S_SCHED_FIND  = 6'b000010,
      S_CANCEL_SCAN = 6'b000100,
      S_TICK_ADV    = 6'b001000,
      S_TICK_SCAN   = 6'b010000,
      S_TICK_EMIT   = 6'b100000
   } state_type;

   // outputs of the shared add / compare unit
   typedef struct packed {
      logic [TIME_W-1:0] sum;
      logic              le;
      logic              eq;
   } alu_res_type;

endpackage

// File: hw/rtl/timeout_table_engine.sv
// timeout_table_engine: table of pending timeouts with lazy cancel
// depends on tte_pkg, tte_alu and tte_slot_mem
//
// Usage
//   Request beat: start with req_opcode, req_delay_ms and req_cancel_id is
//   taken on a rising edge where busy is low. Opcode 3 is dropped.
//   Response beat: rsp_valid is high for one cycle per result; the receiver
//   cannot stall, so every strobed beat is taken. rsp_last marks the final
//   beat of a request. Statistics on every beat are the values after the
//   whole request has been applied.
//   Config: csr_we writes csr_wdata into the tick interval (reset 10); write
//   it only while busy is low and no beat is pending.
// Throughput (one slot a cycle, set by the single slot memory
// read port and the shared add / compare unit)
//   schedule: refused from idle when full, else walks to k, the lowest free slot
//   cancel:   one identifier compared per cycle until a match or the last slot
//   tick:     a clean / compare pass over all slots, then one beat
//             per expired timeout from a second pass over the memory.
//   busy stays high until the sequencer is back in idle; a refused
//   schedule and opcode 3 never raise it.
// Reset: synchronous; the table is empty, time is 0, next id is 1.
module timeout_table_engine
   import tte_pkg::*;
#(
   parameter int SLOTS   = SLOTS_DEF,
   parameter int ID_BITS = ID_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                start,
   output logic                busy,
   input  logic [OP_W-1:0]     req_opcode,
   input  logic [DELAY_W-1:0]  req_delay_ms,
   input  logic [CID_W-1:0]    req_cancel_id,
   // response channel
   output logic                rsp_valid,
   output logic [KIND_W-1:0]   rsp_kind,
   output logic [CID_W-1:0]    rsp_timeout_id,
   output logic                rsp_last,
   output logic [STAT_W-1:0]   rsp_status,
   output logic [OCNT_W-1:0]   rsp_active_count,
   output logic [OCNT_W-1:0]   rsp_cancelled_pending,
   output logic [TOT_W-1:0]    rsp_sched_count,
   output logic [TOT_W-1:0]    rsp_cancel_count,
   output logic [TOT_W-1:0]    rsp_expire_count,
   // config port
   input  logic                csr_we,
   input  logic [INTV_W-1:0]   csr_wdata
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   // sequencer and scan control
   state_type            state_ff, state_in;
   logic [IDX_W:0]       iss_ff, iss_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]     chk_idx_ff, chk_idx_in;

   // slot flags
   logic [SLOTS-1:0]     slot_vld_ff, slot_vld_in;
   logic [SLOTS-1:0]     slot_can_ff, slot_can_in;
   logic [SLOTS-1:0]     exp_mark_ff, exp_mark_in;

   // time, ids and statistics
   logic [TIME_W-1:0]    now_ff, now_in;
   logic [INTV_W-1:0]    intv_ff, intv_in;
   logic [ID_BITS-1:0]   nid_ff, nid_in;
   logic [CNT_W-1:0]     live_ff, live_in;
   logic [CNT_W-1:0]     pend_ff, pend_in;
   logic [CNT_W-1:0]     exp_n_ff, exp_n_in;
   logic [TOT_W-1:0]     sched_tot_ff, sched_tot_in;
   logic [TOT_W-1:0]     can_tot_ff, can_tot_in;
   logic [TOT_W-1:0]     exp_tot_ff, exp_tot_in;

   // latched request fields
   logic [DELAY_W-1:0]   delay_ff, delay_in;
   logic [CID_W-1:0]     cid_ff, cid_in;

   // response beat registers
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;
   logic [CID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [STAT_W-1:0]    rsp_status_ff, rsp_status_in;

   // shared unit and memory hookup
   logic [TIME_W-1:0]    alu_a, alu_b;
   alu_res_type          alu_res;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   logic [ID_BITS-1:0]   rd_ident;
   logic [TIME_W-1:0]    rd_expiry;

   logic                 accept;
   logic                 table_full;
   logic                 issuing;
   logic                 chk_last;
   logic [CNT_W:0]       occupied;

   assign accept     = start && !busy;
   assign occupied   = (CNT_W + 1)'(live_ff) + (CNT_W + 1)'(pend_ff);
   assign table_full = (occupied == (CNT_W + 1)'(SLOTS));
   assign issuing    = (iss_ff != (IDX_W + 1)'(SLOTS));
   assign chk_last   = chk_vld_ff && (chk_idx_ff == IDX_W'(SLOTS - 1));

   tte_alu u_alu (
      .op_a (alu_a),
      .op_b (alu_b),
      .res  (alu_res)
   );

   tte_slot_mem #(
      .SLOTS   (SLOTS),
      .ID_BITS (ID_BITS)
   ) u_mem (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (mem_waddr),
      .wr_ident  (nid_ff),
      .wr_expiry (alu_res.sum),
      .rd_addr   (iss_ff[IDX_W-1:0]),
      .rd_ident  (rd_ident),
      .rd_expiry (rd_expiry)
   );

   // operand select for the shared unit
   always_comb begin
      alu_a = '0;
      alu_b = '0;
      unique case (state_ff)
         S_SCHED_FIND: begin
            alu_a = now_ff;
            alu_b = TIME_W'(delay_ff);
         end
         S_TICK_ADV: begin
            alu_a = now_ff;
            alu_b = TIME_W'(intv_ff);
         end
         S_CANCEL_SCAN: begin
            alu_a = TIME_W'(rd_ident);
            alu_b = TIME_W'(cid_ff);
         end
         S_TICK_SCAN: begin
            alu_a = rd_expiry;
            alu_b = now_ff;
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      iss_in        = iss_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = iss_ff[IDX_W-1:0];
      slot_vld_in   = slot_vld_ff;
      slot_can_in   = slot_can_ff;
      exp_mark_in   = exp_mark_ff;
      now_in        = now_ff;
      intv_in       = csr_we ? csr_wdata : intv_ff;
      nid_in        = nid_ff;
      live_in       = live_ff;
      pend_in       = pend_ff;
      exp_n_in      = exp_n_ff;
      sched_tot_in  = sched_tot_ff;
      can_tot_in    = can_tot_ff;
      exp_tot_in    = exp_tot_ff;
      delay_in      = delay_ff;
      cid_in        = cid_ff;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = iss_ff[IDX_W-1:0];

      unique case (state_ff)
         // take a request beat
         S_IDLE: begin
            if (accept) begin
               delay_in = req_delay_ms;
               cid_in   = req_cancel_id;
               iss_in   = '0;
               priority if (req_opcode == OP_SCHED) begin
                  if (table_full) begin
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = KIND_SCHED;
                     rsp_id_in     = '0;
                     rsp_last_in   = 1'b1;
                     rsp_status_in = ST_FULL;
                  end else begin
                     state_in = S_SCHED_FIND;
                  end
               end else if (req_opcode == OP_CANCEL) begin
                  state_in = S_CANCEL_SCAN;
               end else if (req_opcode == OP_TICK) begin
                  state_in = S_TICK_ADV;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         // walk the valid flags to the lowest free slot, then store there
         S_SCHED_FIND: begin
            if (!slot_vld_ff[iss_ff[IDX_W-1:0]]) begin
               mem_we                          = 1'b1;
               slot_vld_in[iss_ff[IDX_W-1:0]]  = 1'b1;
               slot_can_in[iss_ff[IDX_W-1:0]]  = 1'b0;
               nid_in                          = nid_ff + ID_BITS'(1);
               live_in                         = live_ff + CNT_W'(1);
               sched_tot_in                    = sched_tot_ff + TOT_W'(1);
               rsp_valid_in                    = 1'b1;
               rsp_kind_in                     = KIND_SCHED;
               rsp_id_in                       = CID_W'(nid_ff);
               rsp_last_in                     = 1'b1;
               rsp_status_in                   = ST_OK;
               state_in                        = S_IDLE;
            end else begin
               iss_in = iss_ff + (IDX_W + 1)'(1);
            end
         end

         // compare one stored id per cycle against the cancel id
         S_CANCEL_SCAN: begin
            if (issuing) begin
               iss_in     = iss_ff + (IDX_W + 1)'(1);
               chk_vld_in = 1'b1;
            end
            if (chk_vld_ff && slot_vld_ff[chk_idx_ff] && !slot_can_ff[chk_idx_ff]
                && alu_res.eq) begin
               slot_can_in[chk_idx_ff] = 1'b1;
               live_in                 = live_ff - CNT_W'(1);
               pend_in                 = pend_ff + CNT_W'(1);
               can_tot_in              = can_tot_ff + TOT_W'(1);
               rsp_valid_in            = 1'b1;
               rsp_kind_in             = KIND_CANCEL;
               rsp_id_in               = cid_ff;
               rsp_last_in             = 1'b1;
               rsp_status_in           = ST_OK;
               chk_vld_in              = 1'b0;
               state_in                = S_IDLE;
            end else if (chk_last) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_CANCEL;
               rsp_id_in     = cid_ff;
               rsp_last_in   = 1'b1;
               rsp_status_in = ST_NOT_FOUND;
               chk_vld_in    = 1'b0;
               state_in      = S_IDLE;
            end
         end

         // advance time, clear the expiry marks
         S_TICK_ADV: begin
            now_in      = alu_res.sum;
            exp_mark_in = '0;
            exp_n_in    = '0;
            iss_in      = '0;
            state_in    = S_TICK_SCAN;
         end

         // free cancelled slots and mark expired ones
         S_TICK_SCAN: begin
            if (issuing) begin
               iss_in     = iss_ff + (IDX_W + 1)'(1);
               chk_vld_in = 1'b1;
            end
            if (chk_vld_ff && slot_vld_ff[chk_idx_ff]) begin
               if (slot_can_ff[chk_idx_ff]) begin
                  slot_vld_in[chk_idx_ff] = 1'b0;
                  slot_can_in[chk_idx_ff] = 1'b0;
                  pend_in                 = pend_ff - CNT_W'(1);
               end else if (alu_res.le) begin
                  slot_vld_in[chk_idx_ff] = 1'b0;
                  exp_mark_in[chk_idx_ff] = 1'b1;
                  live_in                 = live_ff - CNT_W'(1);
                  exp_tot_in              = exp_tot_ff + TOT_W'(1);
                  exp_n_in                = exp_n_ff + CNT_W'(1);
               end
            end
            if (chk_last) begin
               iss_in     = '0;
               chk_vld_in = 1'b0;
               if (exp_n_in == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = KIND_IDLE;
                  rsp_id_in     = '0;
                  rsp_last_in   = 1'b1;
                  rsp_status_in = ST_OK;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_TICK_EMIT;
               end
            end
         end

         // second pass: one beat per marked slot, in slot order
         S_TICK_EMIT: begin
            if (issuing) begin
               iss_in     = iss_ff + (IDX_W + 1)'(1);
               chk_vld_in = 1'b1;
            end
            if (chk_vld_ff && exp_mark_ff[chk_idx_ff]) begin
               exp_mark_in[chk_idx_ff] = 1'b0;
               exp_n_in                = exp_n_ff - CNT_W'(1);
               rsp_valid_in            = 1'b1;
               rsp_kind_in             = KIND_EXPIRED;
               rsp_id_in               = CID_W'(rd_ident);
               rsp_status_in           = ST_OK;
               rsp_last_in             = (exp_n_ff == CNT_W'(1));
               if (exp_n_ff == CNT_W'(1)) begin
                  chk_vld_in = 1'b0;
                  state_in   = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iss_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         slot_vld_ff  <= '0;
         slot_can_ff  <= '0;
         exp_mark_ff  <= '0;
         now_ff       <= '0;
         intv_ff      <= TICK_INTV_RST;
         nid_ff       <= ID_BITS'(1);
         live_ff      <= '0;
         pend_ff      <= '0;
         exp_n_ff     <= '0;
         sched_tot_ff <= '0;
         can_tot_ff   <= '0;
         exp_tot_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         chk_vld_ff   <= chk_vld_in;
         slot_vld_ff  <= slot_vld_in;
         slot_can_ff  <= slot_can_in;
         exp_mark_ff  <= exp_mark_in;
         now_ff       <= now_in;
         intv_ff      <= intv_in;
         nid_ff       <= nid_in;
         live_ff      <= live_in;
         pend_ff      <= pend_in;
         exp_n_ff     <= exp_n_in;
         sched_tot_ff <= sched_tot_in;
         can_tot_ff   <= can_tot_in;
         exp_tot_ff   <= exp_tot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      chk_idx_ff    <= chk_idx_in;
      delay_ff      <= delay_in;
      cid_ff        <= cid_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   // outputs
   assign busy                  = (state_ff != S_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_kind              = rsp_kind_ff;
   assign rsp_timeout_id        = rsp_id_ff;
   assign rsp_last              = rsp_last_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_active_count      = OCNT_W'(live_ff);
   assign rsp_cancelled_pending = OCNT_W'(pend_ff);
   assign rsp_sched_count       = sched_tot_ff;
   assign rsp_cancel_count      = can_tot_ff;
   assign rsp_expire_count      = exp_tot_ff;

   // occupied slots never exceed the table
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      occupied <= (CNT_W + 1)'(SLOTS))
      else $error("slot occupancy beyond table size");

   // a schedule into a full table is refused in the next cycle
   a_full_refuse: assert property (@(posedge clock) disable iff (reset)
      accept && (req_opcode == OP_SCHED) && table_full
      |=> rsp_valid && (rsp_status == ST_FULL) && rsp_last)
      else $error("full table not refused");

   // the final beat of a request coincides with the sequencer back at idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("last beat while still busy");

   // a non-final beat only comes from an unfinished tick
   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy && (rsp_kind == KIND_EXPIRED))
      else $error("non-final beat outside a tick");

endmodule

// File: hw/rtl/tte_alu.sv
// tte_alu: shared 48-bit add and unsigned compare unit
// depends on tte_pkg
module tte_alu
   import tte_pkg::*;
(
   input  logic [TIME_W-1:0] op_a,
   input  logic [TIME_W-1:0] op_b,
   output alu_res_type       res
);

   // wrapping sum plus less-or-equal and equality of the same operands
   always_comb begin
      res.sum = op_a + op_b;
      res.le  = (op_a <= op_b);
      res.eq  = (op_a == op_b);
   end

endmodule

// File: hw/rtl/tte_slot_mem.sv
// tte_slot_mem: identifier and expiry storage of the timeout slots
// depends on tte_pkg; one write port, one registered read port
module tte_slot_mem
   import tte_pkg::*;
#(
   parameter int SLOTS   = SLOTS_DEF,
   parameter int ID_BITS = ID_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(SLOTS)-1:0] wr_addr,
   input  logic [ID_BITS-1:0]       wr_ident,
   input  logic [TIME_W-1:0]        wr_expiry,
   input  logic [$clog2(SLOTS)-1:0] rd_addr,
   output logic [ID_BITS-1:0]       rd_ident,
   output logic [TIME_W-1:0]        rd_expiry
);

   logic [ID_BITS-1:0] ident_mem  [SLOTS];
   logic [TIME_W-1:0]  expiry_mem [SLOTS];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ident_mem[wr_addr]  <= wr_ident;
         expiry_mem[wr_addr] <= wr_expiry;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_ident  <= ident_mem[rd_addr];
      rd_expiry <= expiry_mem[rd_addr];
   end

endmodule

// File: verif/timeout_table_engine_checker.sv
`timescale 1ns / 100ps
// timeout_table_engine_checker: watches the request, response and config ports,
// keeps its own copy of the timeout table and compares every response beat
// depends on tte_pkg
module timeout_table_engine_checker
   import tte_pkg::*;
#(
   parameter int SLOTS   = SLOTS_DEF,
   parameter int ID_BITS = ID_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [OP_W-1:0]    req_opcode,
   input  logic [DELAY_W-1:0] req_delay_ms,
   input  logic [CID_W-1:0]   req_cancel_id,
   input  logic               rsp_valid,
   input  logic [KIND_W-1:0]  rsp_kind,
   input  logic [CID_W-1:0]   rsp_timeout_id,
   input  logic               rsp_last,
   input  logic [STAT_W-1:0]  rsp_status,
   input  logic [OCNT_W-1:0]  rsp_active_count,
   input  logic [OCNT_W-1:0]  rsp_cancelled_pending,
   input  logic [TOT_W-1:0]   rsp_sched_count,
   input  logic [TOT_W-1:0]   rsp_cancel_count,
   input  logic [TOT_W-1:0]   rsp_expire_count,
   input  logic               csr_we,
   input  logic [INTV_W-1:0]  csr_wdata,
   output int                 fail_count,
   output int                 pending_beats,
   output int                 beats_checked,
   output int                 requests_taken
);

   // one response beat as the table should produce it
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CID_W-1:0]  id;
      logic              last;
      logic [STAT_W-1:0] status;
      logic [OCNT_W-1:0] active;
      logic [OCNT_W-1:0] cpend;
      logic [TOT_W-1:0]  sched_tot;
      logic [TOT_W-1:0]  cancel_tot;
      logic [TOT_W-1:0]  expire_tot;
   } timer_beat_type;

   // shadow of the timeout table
   bit                 slot_used   [SLOTS];
   bit                 slot_killed [SLOTS];
   logic [ID_BITS-1:0] slot_tag    [SLOTS];
   logic [TIME_W-1:0]  slot_due    [SLOTS];
   logic [ID_BITS-1:0] id_next;
   logic [TIME_W-1:0]  now_ms;
   logic [INTV_W-1:0]  tick_step;
   logic [OCNT_W-1:0]  live_n;
   logic [OCNT_W-1:0]  killed_n;
   logic [TOT_W-1:0]   sched_n;
   logic [TOT_W-1:0]   cancel_n;
   logic [TOT_W-1:0]   expired_n;

   timer_beat_type due_beats [$];
   int errors = 0;
   int beat_no = 0;
   int taken = 0;

   task automatic clear_table();
      int i;
      for (i = 0; i < SLOTS; i++) begin
         slot_used[i]   = 1'b0;
         slot_killed[i] = 1'b0;
         slot_tag[i]    = '0;
         slot_due[i]    = '0;
      end
      id_next   = ID_BITS'(1);
      now_ms    = '0;
      tick_step = TICK_INTV_RST;
      live_n    = '0;
      killed_n  = '0;
      sched_n   = '0;
      cancel_n  = '0;
      expired_n = '0;
      due_beats.delete();
   endtask

   // apply one accepted request to the shadow table and queue its beats
   task automatic apply_request(input logic [OP_W-1:0] op, input logic [DELAY_W-1:0] dly,
                                input logic [CID_W-1:0] cid);
      timer_beat_type out_beats [$];
      timer_beat_type b;
      int pick;
      int i;
      pick = -1;
      b    = '0;
      case (op)
         OP_SCHED: begin
            // lowest slot that is not occupied, cancelled ones included
            for (i = 0; i < SLOTS; i++)
               if (pick < 0 && !slot_used[i]) pick = i;
            b.kind = KIND_SCHED;
            b.last = 1'b1;
            if (pick < 0) begin
               b.status = ST_FULL;
            end else begin
               slot_used[pick]   = 1'b1;
               slot_killed[pick] = 1'b0;
               slot_tag[pick]    = id_next;
               slot_due[pick]    = now_ms + TIME_W'(dly);
               b.id     = CID_W'(id_next);
               b.status = ST_OK;
               id_next  = id_next + 1'b1;
               live_n   = live_n + 1'b1;
               sched_n  = sched_n + 1'b1;
            end
            out_beats = {out_beats, b};
         end
         OP_CANCEL: begin
            // lowest live entry with a matching id wins
            for (i = 0; i < SLOTS; i++)
               if (pick < 0 && slot_used[i] && !slot_killed[i]
                   && TIME_W'(slot_tag[i]) == TIME_W'(cid))
                  pick = i;
            b.kind = KIND_CANCEL;
            b.id   = cid;
            b.last = 1'b1;
            if (pick < 0) begin
               b.status = ST_NOT_FOUND;
            end else begin
               slot_killed[pick] = 1'b1;
               live_n   = live_n - 1'b1;
               killed_n = killed_n + 1'b1;
               cancel_n = cancel_n + 1'b1;
               b.status = ST_OK;
            end
            out_beats = {out_beats, b};
         end
         OP_TICK: begin
            now_ms = now_ms + TIME_W'(tick_step);
            // clean cancelled slots, emit expired ones in slot order
            for (i = 0; i < SLOTS; i++) begin
               if (slot_used[i]) begin
                  if (slot_killed[i]) begin
                     slot_used[i]   = 1'b0;
                     slot_killed[i] = 1'b0;
                     killed_n = killed_n - 1'b1;
                  end else if (slot_due[i] <= now_ms) begin
                     slot_used[i] = 1'b0;
                     live_n    = live_n - 1'b1;
                     expired_n = expired_n + 1'b1;
                     b.kind   = KIND_EXPIRED;
                     b.id     = CID_W'(slot_tag[i]);
                     b.status = ST_OK;
                     b.last   = 1'b0;
                     out_beats = {out_beats, b};
                  end
               end
            end
            if (out_beats.size() == 0) begin
               b.kind   = KIND_IDLE;
               b.id     = '0;
               b.status = ST_OK;
               b.last   = 1'b1;
               out_beats = {out_beats, b};
            end else begin
               out_beats[out_beats.size() - 1].last = 1'b1;
            end
         end
         default: ;
      endcase
      // statistics are the values after the whole request
      foreach (out_beats[k]) begin
         b            = out_beats[k];
         b.active     = live_n;
         b.cpend      = killed_n;
         b.sched_tot  = sched_n;
         b.cancel_tot = cancel_n;
         b.expire_tot = expired_n;
         due_beats    = {due_beats, b};
      end
   endtask

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [TOT_W-1:0] got,
                              input logic [TOT_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("beat %0d %s: got 0x%0h, expected 0x%0h",
                                   beat_no, name, got, want));
   endtask

   // compare one response beat against the oldest expectation
   task automatic check_beat();
      timer_beat_type want;
      beat_no++;
      if (due_beats.size() == 0) begin
         report_mismatch($sformatf("beat %0d kind %0d id 0x%0h arrived with nothing expected",
                                   beat_no, rsp_kind, rsp_timeout_id));
         return;
      end
      want = due_beats.pop_front();
      check_field("kind", rsp_kind, want.kind);
      check_field("timeout_id", rsp_timeout_id, want.id);
      check_field("last", rsp_last, want.last);
      check_field("status", rsp_status, want.status);
      check_field("active_count", rsp_active_count, want.active);
      check_field("cancelled_pending", rsp_cancelled_pending, want.cpend);
      check_field("sched_count", rsp_sched_count, want.sched_tot);
      check_field("cancel_count", rsp_cancel_count, want.cancel_tot);
      check_field("expire_count", rsp_expire_count, want.expire_tot);
   endtask

   // sample all channels on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         clear_table();
      end else begin
         if (csr_we) tick_step = csr_wdata;
         if (start && !busy) begin
            taken++;
            apply_request(req_opcode, req_delay_ms, req_cancel_id);
         end
         if (rsp_valid) check_beat();
      end
      fail_count     <= errors;
      pending_beats  <= due_beats.size();
      beats_checked  <= beat_no;
      requests_taken <= taken;
   end

endmodule

// File: verif/timeout_table_engine_tb.sv
`timescale 1ns / 100ps
// timeout_table_engine_tb: drives requests and tick interval writes into the engine
// depends on tte_pkg, timeout_table_engine and timeout_table_engine_checker
module timeout_table_engine_tb;
   import tte_pkg::*;

   localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int SETTLE_CYCLES    = 2 * SLOTS_DEF + 8;
   localparam int RANDOM_PER_PHASE = 74;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [OP_W-1:0]    req_opcode = '0;
   logic [DELAY_W-1:0] req_delay_ms = '0;
   logic [CID_W-1:0]   req_cancel_id = '0;
   logic               rsp_valid;
   logic [KIND_W-1:0]  rsp_kind;
   logic [CID_W-1:0]   rsp_timeout_id;
   logic               rsp_last;
   logic [STAT_W-1:0]  rsp_status;
   logic [OCNT_W-1:0]  rsp_active_count;
   logic [OCNT_W-1:0]  rsp_cancelled_pending;
   logic [TOT_W-1:0]   rsp_sched_count;
   logic [TOT_W-1:0]   rsp_cancel_count;
   logic [TOT_W-1:0]   rsp_expire_count;
   logic               csr_we = 1'b0;
   logic [INTV_W-1:0]  csr_wdata = '0;

   int fail_count;
   int pending_beats;
   int beats_checked;
   int requests_taken;

   // ids handed out lately, used to aim cancels at live entries
   logic [CID_W-1:0]  recent_ids [16] = '{default: '0};
   int                recent_wr = 0;
   logic [CID_W-1:0]  last_id = '0;
   int                burst_left = 0;
   logic [INTV_W-1:0] tick_len = TICK_INTV_RST;

   timeout_table_engine uut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_opcode            (req_opcode),
      .req_delay_ms          (req_delay_ms),
      .req_cancel_id         (req_cancel_id),
      .rsp_valid             (rsp_valid),
      .rsp_kind              (rsp_kind),
      .rsp_timeout_id        (rsp_timeout_id),
      .rsp_last              (rsp_last),
      .rsp_status            (rsp_status),
      .rsp_active_count      (rsp_active_count),
      .rsp_cancelled_pending (rsp_cancelled_pending),
      .rsp_sched_count       (rsp_sched_count),
      .rsp_cancel_count      (rsp_cancel_count),
      .rsp_expire_count      (rsp_expire_count),
      .csr_we                (csr_we),
      .csr_wdata             (csr_wdata)
   );

   timeout_table_engine_checker table_check (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_opcode            (req_opcode),
      .req_delay_ms          (req_delay_ms),
      .req_cancel_id         (req_cancel_id),
      .rsp_valid             (rsp_valid),
      .rsp_kind              (rsp_kind),
      .rsp_timeout_id        (rsp_timeout_id),
      .rsp_last              (rsp_last),
      .rsp_status            (rsp_status),
      .rsp_active_count      (rsp_active_count),
      .rsp_cancelled_pending (rsp_cancelled_pending),
      .rsp_sched_count       (rsp_sched_count),
      .rsp_cancel_count      (rsp_cancel_count),
      .rsp_expire_count      (rsp_expire_count),
      .csr_we                (csr_we),
      .csr_wdata             (csr_wdata),
      .fail_count            (fail_count),
      .pending_beats         (pending_beats),
      .beats_checked         (beats_checked),
      .requests_taken        (requests_taken)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // remember ids of successful schedules
   always @(posedge clock) begin
      if (rsp_valid && rsp_kind == KIND_SCHED && rsp_status == ST_OK) begin
         recent_ids[recent_wr % 16] <= rsp_timeout_id;
         recent_wr <= recent_wr + 1;
         last_id   <= rsp_timeout_id;
      end
   end

   // present one request beat until it is taken, then maybe pause
   task automatic issue_request(input logic [OP_W-1:0] op, input logic [DELAY_W-1:0] dly,
                                input logic [CID_W-1:0] cid);
      start         <= 1'b1;
      req_opcode    <= op;
      req_delay_ms  <= dly;
      req_cancel_id <= cid;
      do @(posedge clock); while (busy);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(0, 15);
      end
   endtask

   // drain every expected beat, then let the engine settle
   task automatic wait_quiet();
      start <= 1'b0;
      do @(posedge clock); while (pending_beats != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_interval(input logic [INTV_W-1:0] value);
      wait_quiet();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      tick_len = value;
   endtask

   // mostly delays that expire within a few ticks, plus the extremes
   function automatic logic [DELAY_W-1:0] pick_delay();
      int r;
      int span;
      r    = $urandom_range(0, 99);
      span = int'(tick_len) * 6 + 3;
      if (r < 10) return '0;
      if (r < 15) return '1;
      if (r < 25) return DELAY_W'($urandom());
      return DELAY_W'($urandom_range(0, span));
   endfunction

   function automatic logic [CID_W-1:0] pick_cancel_id();
      if ($urandom_range(0, 3) != 0) return recent_ids[$urandom_range(0, 15)];
      return CID_W'($urandom());
   endfunction

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid === 1'b1) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("timeout_table_engine verification failed");
      $finish;
   end

   initial begin : stimulus
      int ph;
      int n;
      int r;
      logic [CID_W-1:0]  anchor_id;
      logic [INTV_W-1:0] phase_intv [5];
      phase_intv[0] = 16'd1;
      phase_intv[1] = 16'd0;
      phase_intv[2] = 16'hFFFF;
      phase_intv[3] = INTV_W'($urandom_range(2, 65534));
      phase_intv[4] = INTV_W'($urandom_range(2, 200));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty tick, cancel hits and misses, ignored opcode
      issue_request(OP_TICK, '0, '0);
      issue_request(OP_SCHED, '0, '0);
      issue_request(OP_SCHED, '1, '0);
      issue_request(OP_SCHED, 24'd5, '0);
      issue_request(OP_CANCEL, '1, 16'd2);
      issue_request(OP_CANCEL, '0, 16'd2);
      issue_request(OP_CANCEL, '0, '1);
      issue_request(OP_IGNORED, '1, '1);
      issue_request(OP_TICK, '1, '1);
      // fill the table, get refused, then expire all slots in one tick
      repeat (SLOTS_DEF) issue_request(OP_SCHED, '0, '0);
      issue_request(OP_SCHED, 24'd1, '0);
      issue_request(OP_TICK, '0, '0);

      // a long entry parks in slot 0 and is cancelled, then double cancels miss
      write_interval(16'd3);
      issue_request(OP_SCHED, '1, '0);
      wait_quiet();
      anchor_id = last_id;
      issue_request(OP_SCHED, '0, '0);
      issue_request(OP_CANCEL, '0, anchor_id);
      issue_request(OP_CANCEL, '0, anchor_id);
      issue_request(OP_CANCEL, '0, anchor_id);
      // full while the only free room is a cancelled slot
      repeat (SLOTS_DEF - 2) issue_request(OP_SCHED, '0, '0);
      issue_request(OP_SCHED, 24'd7, '0);
      issue_request(OP_TICK, '0, '0);

      // random traffic under several tick intervals
      for (ph = 0; ph < 5; ph++) begin
         write_interval(phase_intv[ph]);
         n = 0;
         while (n < RANDOM_PER_PHASE) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
               issue_request(OP_SCHED, pick_delay(), CID_W'($urandom()));
               n++;
            end else if (r < 65) begin
               issue_request(OP_CANCEL, DELAY_W'($urandom()), pick_cancel_id());
               n++;
            end else if (r < 95) begin
               issue_request(OP_TICK, DELAY_W'($urandom()), CID_W'($urandom()));
               n++;
            end else begin
               issue_request(OP_IGNORED, DELAY_W'($urandom()), CID_W'($urandom()));
            end
         end
      end

      wait_quiet();
      $display("covered %0d requests and %0d response beats under random bursts",
               requests_taken, beats_checked);
      $display("tick intervals 10 3 1 0 65535 %0d %0d, table full and lazy cancel hit",
               phase_intv[3], phase_intv[4]);
      if (fail_count == 0 && pending_beats == 0) begin
         $display("timeout_table_engine verification clean");
      end else begin
         $display("timeout_table_engine verification failed");
      end
      $finish;
   end

endmodule

// File: timeout_table_engine.f
hw/rtl/tte_pkg.sv
hw/rtl/tte_alu.sv
hw/rtl/tte_slot_mem.sv
hw/rtl/timeout_table_engine.sv
verif/timeout_table_engine_checker.sv
verif/timeout_table_engine_tb.sv
